>>> src/maxr_pkg.sv
// shared types and constants for the maxrects rectangle allocator
// no dependencies; imported by maxr_score and the allocator top module
`timescale 1ns / 1ps

package maxr_pkg;

   // default sizing
   localparam int MAX_FREE_RECTS_DEF = 64;
   localparam int COORD_BITS_DEF     = 16;

   // configuration register indexes
   localparam logic [2:0] REG_BIN_MAX_WIDTH  = 3'd0;
   localparam logic [2:0] REG_BIN_MAX_HEIGHT = 3'd1;
   localparam logic [2:0] REG_EDGE_PADDING   = 3'd2;
   localparam logic [2:0] REG_BORDER_MARGIN  = 3'd3;
   localparam logic [2:0] REG_FIT_HEURISTIC  = 3'd4;
   localparam logic [2:0] REG_ALLOW_ROTATION = 3'd5;
   localparam logic [2:0] REG_SIZE_MODE      = 3'd6;

   // register reset values
   localparam logic [15:0] BIN_MAX_RESET = 16'd1024;

   // fit heuristics
   localparam logic [1:0] HEUR_SHORT_SIDE = 2'd0;
   localparam logic [1:0] HEUR_LONG_SIDE  = 2'd1;
   localparam logic [1:0] HEUR_AREA       = 2'd2;

   // request actions
   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // size mode bit positions
   localparam int MODE_SMART  = 0;
   localparam int MODE_POW2   = 1;
   localparam int MODE_SQUARE = 2;

   // index of the last split fragment per overlapped entry
   localparam logic [1:0] FRAG_LAST = 2'd3;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_FIND_RD,
      ST_FIND_EV,
      ST_FIND_CMP,
      ST_PASS1_RD,
      ST_PASS1_EV,
      ST_PASS2_RD,
      ST_PASS2_EV,
      ST_FRAG,
      ST_PR_I_RD,
      ST_PR_I_EV,
      ST_PR_J_RD,
      ST_PR_J_EV,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_POW2,
      ST_RESP
   } state_type;

endpackage

>>> src/maxr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module maxr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/maxr_score.sv
// fit test and heuristic score of one free entry, registered
// depends on maxr_pkg for the heuristic codes
`timescale 1ns / 1ps

module maxr_score #(
   parameter int COORD_BITS = maxr_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [1:0]                heur,
   input  logic [COORD_BITS:0]       fx,
   input  logic [COORD_BITS:0]       fy,
   input  logic [COORD_BITS:0]       fw,
   input  logic [COORD_BITS:0]       fh,
   input  logic [15:0]               tw,
   input  logic [15:0]               th,
   output logic                      fit,
   output logic [2*COORD_BITS+1:0]   prim,
   output logic [COORD_BITS:0]       sec,
   output logic [COORD_BITS:0]       px,
   output logic [COORD_BITS:0]       py
);

   import maxr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int PW = 2 * XW;
   localparam int WW = (XW > 16) ? XW : 16;

   logic [WW-1:0] fw_e, fh_e, tw_e, th_e;
   logic [XW-1:0] lh, lv, sh, lg;
   logic [PW-1:0] area;
   logic          fit_in;
   logic [PW-1:0] prim_in;
   logic [XW-1:0] sec_in;

   logic          fit_ff;
   logic [PW-1:0] prim_ff;
   logic [XW-1:0] sec_ff, px_ff, py_ff;

   // leftover sides and area of the candidate
   always_comb begin
      fw_e   = WW'(fw);
      fh_e   = WW'(fh);
      tw_e   = WW'(tw);
      th_e   = WW'(th);
      fit_in = (fw_e >= tw_e) && (fh_e >= th_e);
      lh     = XW'(fw_e - tw_e);
      lv     = XW'(fh_e - th_e);
      sh     = (lh < lv) ? lh : lv;
      lg     = (lh < lv) ? lv : lh;
      area   = PW'(fw) * PW'(fh);
      case (heur)
         HEUR_LONG_SIDE: begin
            prim_in = PW'(lg);
            sec_in  = sh;
         end
         HEUR_AREA: begin
            prim_in = area;
            sec_in  = sh;
         end
         default: begin
            prim_in = PW'(sh);
            sec_in  = lg;
         end
      endcase
   end

   // score register
   always_ff @(posedge clock) begin
      if (en) begin
         fit_ff  <= fit_in;
         prim_ff <= prim_in;
         sec_ff  <= sec_in;
         px_ff   <= fx;
         py_ff   <= fy;
      end
   end

   assign fit  = fit_ff;
   assign prim = prim_ff;
   assign sec  = sec_ff;
   assign px   = px_ff;
   assign py   = py_ff;

endmodule

>>> src/maxrects_rect_allocator_top.sv
// maxrects rectangle allocator: control sequencer, free list and scratch rams
// depends on maxr_pkg, maxr_ram and maxr_score
`timescale 1ns / 1ps

// One request at a time: a request is taken when start is high and busy is low,
// and its result beat appears on rsp_* for exactly one cycle with rsp_strobe;
// the receiver must take it then. A clear rewrites the initial free rectangle. An
// add first scores every free entry for the requested size, and again for the
// rotated size when rotation is allowed and nothing fit; it then copies untouched
// entries into the scratch ram, splits each overlapped entry into up to four
// fragments appended there, prunes contained entries with pairwise reads of the
// scratch ram, copies the survivors back and tracks the power-of-two size. The
// pace of the prune is set by the single read port of the scratch ram.
// Register writes are taken only while the block is idle (csr_ready low while busy).
// After reset the block writes the initial free rectangle in ST_INIT before going idle.
module maxrects_rect_allocator_top #(
   parameter int MAX_FREE_RECTS = maxr_pkg::MAX_FREE_RECTS_DEF,
   parameter int COORD_BITS     = maxr_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_rect_width,
   input  logic [15:0] req_rect_height,
   // result channel
   output logic        rsp_strobe,
   output logic        rsp_placed,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic        rsp_rotated,
   output logic [16:0] rsp_used_width,
   output logic [16:0] rsp_used_height,
   output logic        rsp_list_overflow,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import maxr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int EW = 4 * XW + 1;
   localparam int PW = 2 * XW;
   localparam int AW = $clog2(MAX_FREE_RECTS);
   localparam int CW = $clog2(MAX_FREE_RECTS + 1);
   localparam int IW = (XW + 1 > 18) ? XW + 1 : 18;

   // span of the initial free rectangle along one axis
   function automatic logic [XW-1:0] span_of(input logic [15:0] mx, input logic [7:0] pad,
                                             input logic [7:0] brd);
      logic [IW-1:0] t, b2, w, cap;
      t   = IW'(mx) + IW'(pad);
      b2  = IW'(brd) << 1;
      w   = (t < b2) ? '0 : t - b2;
      cap = IW'(1) << COORD_BITS;
      if (IW'(brd) + w > cap) begin
         w = cap - IW'(brd);
      end
      return XW'(w);
   endfunction

   // state and registers
   state_type     state_ff, state_in;
   logic [15:0]   bmw_ff, bmw_in, bmh_ff, bmh_in;
   logic [7:0]    pad_ff, pad_in, border_ff, border_in;
   logic [1:0]    heur_ff, heur_in;
   logic          rot_ff, rot_in;
   logic [2:0]    mode_ff, mode_in;

   logic [15:0]   w_ff, w_in, h_ff, h_in, tw_ff, tw_in, th_ff, th_in;
   logic          rot_try_ff, rot_try_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, jdx_ff, jdx_in;
   logic [CW-1:0] nb_ff, nb_in, m_ff, m_in;
   logic          found_ff, found_in;
   logic [PW-1:0] bp_ff, bp_in;
   logic [XW-1:0] bs_ff, bs_in, bx_ff, bx_in, by_ff, by_in;
   logic [XW-1:0] ux_ff, ux_in, uy_ff, uy_in, uw_ff, uw_in, uh_ff, uh_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [1:0]    k_ff, k_in;
   logic          placed_ff, placed_in, ovf_ff, ovf_in;
   logic [XW-1:0] extx_ff, extx_in, exty_ff, exty_in, p2x_ff, p2x_in, p2y_ff, p2y_in;
   logic          any_ff, any_in;

   logic          rsp_strobe_ff, rsp_strobe_in, rsp_placed_ff, rsp_placed_in;
   logic [15:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic          rsp_rot_ff, rsp_rot_in, rsp_ovf_ff, rsp_ovf_in;
   logic [16:0]   rsp_uw_ff, rsp_uw_in, rsp_uh_ff, rsp_uh_in;

   // ram ports
   logic          a_we, b_we;
   logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
   logic [EW-1:0] a_wdata, a_rdata, b_wdata, b_rdata;

   // score unit
   logic          sc_en, sc_fit;
   logic [PW-1:0] sc_p;
   logic [XW-1:0] sc_s, sc_x, sc_y;

   // unpacked fields
   logic [XW-1:0] ax, ay, aw, ah, bx, by, bw, bh, cx, cy, cw, ch;
   logic          b_del;
   logic [XW:0]   a_r, a_b, b_r, b_b, c_r, c_b, u_r, u_b;
   logic          a_ovl, cur_in_b, b_in_cur, better;
   logic          find_done, pass_done, j_done, cmp_done, idx_zero, nb_room, p2_done;
   logic [3:0]    frag_en;
   logic [EW-1:0] frag_data [4];
   logic [XW-1:0] init_w, init_h, new_ex, new_ey;
   logic [XW-1:0] size_w, size_h;

   maxr_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_RECTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   maxr_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_RECTS)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   maxr_score #(.COORD_BITS(COORD_BITS)) u_score (
      .clock (clock),
      .en    (sc_en),
      .heur  (heur_ff),
      .fx    (ax),
      .fy    (ay),
      .fw    (aw),
      .fh    (ah),
      .tw    (tw_ff),
      .th    (th_ff),
      .fit   (sc_fit),
      .prim  (sc_p),
      .sec   (sc_s),
      .px    (sc_x),
      .py    (sc_y)
   );

   // entry fields and geometry tests
   always_comb begin
      {ax, ay, aw, ah} = a_rdata[EW-2:0];
      {b_del, bx, by, bw, bh} = b_rdata;
      {cx, cy, cw, ch} = cur_ff[EW-2:0];
      a_r = {1'b0, ax} + {1'b0, aw};
      a_b = {1'b0, ay} + {1'b0, ah};
      b_r = {1'b0, bx} + {1'b0, bw};
      b_b = {1'b0, by} + {1'b0, bh};
      c_r = {1'b0, cx} + {1'b0, cw};
      c_b = {1'b0, cy} + {1'b0, ch};
      u_r = {1'b0, ux_ff} + {1'b0, uw_ff};
      u_b = {1'b0, uy_ff} + {1'b0, uh_ff};
      a_ovl = !(({1'b0, ux_ff} >= a_r) || (u_r <= {1'b0, ax}) ||
                ({1'b0, uy_ff} >= a_b) || (u_b <= {1'b0, ay}));
      cur_in_b = (cx >= bx) && (cy >= by) && (c_r <= b_r) && (c_b <= b_b);
      b_in_cur = (bx >= cx) && (by >= cy) && (b_r <= c_r) && (b_b <= c_b);
      better = sc_fit && (!found_ff || (sc_p < bp_ff) ||
                          ((sc_p == bp_ff) && (sc_s < bs_ff)));
      // split fragments: above, below, left, right
      frag_en[0] = (uy_ff > cy) && ({1'b0, uy_ff} < c_b);
      frag_en[1] = (u_b < c_b);
      frag_en[2] = (ux_ff > cx) && ({1'b0, ux_ff} < c_r);
      frag_en[3] = (u_r < c_r);
      frag_data[0] = {1'b0, cx, cy, cw, XW'(uy_ff - cy)};
      frag_data[1] = {1'b0, cx, XW'(u_b), cw, XW'(c_b - u_b)};
      frag_data[2] = {1'b0, cx, cy, XW'(ux_ff - cx), ch};
      frag_data[3] = {1'b0, XW'(u_r), cy, XW'(c_r - u_r), ch};
   end

   // loop conditions
   always_comb begin
      find_done = (idx_ff >= cnt_ff);
      pass_done = (idx_ff >= cnt_ff);
      j_done    = (jdx_ff >= nb_ff);
      cmp_done  = (idx_ff >= nb_ff);
      idx_zero  = (idx_ff == '0);
      nb_room   = (nb_ff < CW'(MAX_FREE_RECTS));
      p2_done   = (p2x_ff >= extx_ff) && (p2y_ff >= exty_ff);
      init_w    = span_of(bmw_ff, pad_ff, border_ff);
      init_h    = span_of(bmh_ff, pad_ff, border_ff);
      new_ex    = bx_ff + XW'(tw_ff);
      new_ey    = by_ff + XW'(th_ff);
   end

   // used bin size from the current registers
   always_comb begin
      size_w = mode_ff[MODE_POW2] ? p2x_ff : extx_ff;
      size_h = mode_ff[MODE_POW2] ? p2y_ff : exty_ff;
      if (mode_ff[MODE_SQUARE]) begin
         if (size_w < size_h) begin
            size_w = size_h;
         end else begin
            size_h = size_w;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_rect_width == '0 || req_rect_height == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_CLEAR: state_in = ST_RESP;
         ST_FIND_RD: begin
            if (!find_done) begin
               state_in = ST_FIND_EV;
            end else if (found_ff) begin
               state_in = ST_PASS1_RD;
            end else if (rot_ff && !rot_try_ff) begin
               state_in = ST_FIND_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FIND_EV:  state_in = ST_FIND_CMP;
         ST_FIND_CMP: state_in = ST_FIND_RD;
         ST_PASS1_RD: state_in = pass_done ? ST_PASS2_RD : ST_PASS1_EV;
         ST_PASS1_EV: state_in = ST_PASS1_RD;
         ST_PASS2_RD: begin
            if (!pass_done) begin
               state_in = ST_PASS2_EV;
            end else if (nb_ff == '0) begin
               state_in = ST_CMP_RD;
            end else begin
               state_in = ST_PR_I_RD;
            end
         end
         ST_PASS2_EV: state_in = a_ovl ? ST_FRAG : ST_PASS2_RD;
         ST_FRAG:     state_in = (k_ff == FRAG_LAST) ? ST_PASS2_RD : ST_FRAG;
         ST_PR_I_RD:  state_in = ST_PR_I_EV;
         ST_PR_I_EV:  state_in = ST_PR_J_RD;
         ST_PR_J_RD: begin
            if (!j_done) begin
               state_in = ST_PR_J_EV;
            end else begin
               state_in = idx_zero ? ST_CMP_RD : ST_PR_I_RD;
            end
         end
         ST_PR_J_EV: begin
            if (!b_del && cur_in_b) begin
               state_in = idx_zero ? ST_CMP_RD : ST_PR_I_RD;
            end else begin
               state_in = ST_PR_J_RD;
            end
         end
         ST_CMP_RD: state_in = cmp_done ? ST_POW2 : ST_CMP_EV;
         ST_CMP_EV: state_in = ST_CMP_RD;
         ST_POW2:   state_in = p2_done ? ST_RESP : ST_POW2;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      bmw_in = bmw_ff;  bmh_in = bmh_ff;  pad_in = pad_ff;  border_in = border_ff;
      heur_in = heur_ff;  rot_in = rot_ff;  mode_in = mode_ff;
      w_in = w_ff;  h_in = h_ff;  tw_in = tw_ff;  th_in = th_ff;  rot_try_in = rot_try_ff;
      cnt_in = cnt_ff;  idx_in = idx_ff;  jdx_in = jdx_ff;  nb_in = nb_ff;  m_in = m_ff;
      found_in = found_ff;  bp_in = bp_ff;  bs_in = bs_ff;  bx_in = bx_ff;  by_in = by_ff;
      ux_in = ux_ff;  uy_in = uy_ff;  uw_in = uw_ff;  uh_in = uh_ff;
      cur_in = cur_ff;  k_in = k_ff;  placed_in = placed_ff;  ovf_in = ovf_ff;
      extx_in = extx_ff;  exty_in = exty_ff;  p2x_in = p2x_ff;  p2y_in = p2y_ff;
      any_in = any_ff;
      rsp_strobe_in = 1'b0;  rsp_placed_in = rsp_placed_ff;  rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;  rsp_rot_in = rsp_rot_ff;  rsp_ovf_in = rsp_ovf_ff;
      rsp_uw_in = rsp_uw_ff;  rsp_uh_in = rsp_uh_ff;
      a_we = 1'b0;  a_waddr = '0;  a_wdata = '0;  a_raddr = idx_ff[AW-1:0];
      b_we = 1'b0;  b_waddr = nb_ff[AW-1:0];  b_wdata = '0;  b_raddr = idx_ff[AW-1:0];
      sc_en = 1'b0;

      // configuration beat
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BIN_MAX_WIDTH:  bmw_in = csr_wdata;
            REG_BIN_MAX_HEIGHT: bmh_in = csr_wdata;
            REG_EDGE_PADDING:   pad_in = csr_wdata[7:0];
            REG_BORDER_MARGIN:  border_in = csr_wdata[7:0];
            REG_FIT_HEURISTIC:  heur_in = csr_wdata[1:0];
            REG_ALLOW_ROTATION: rot_in = csr_wdata[0];
            REG_SIZE_MODE:      mode_in = csr_wdata[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            a_we    = 1'b1;
            a_waddr = '0;
            a_wdata = {1'b0, XW'(border_ff), XW'(border_ff), init_w, init_h};
            cnt_in  = CW'(1);
            extx_in = '0;
            exty_in = '0;
            p2x_in  = XW'(1);
            p2y_in  = XW'(1);
            any_in  = 1'b0;
         end
         ST_IDLE: begin
            if (start) begin
               w_in       = req_rect_width;
               h_in       = req_rect_height;
               tw_in      = req_rect_width;
               th_in      = req_rect_height;
               rot_try_in = 1'b0;
               found_in   = 1'b0;
               idx_in     = '0;
               placed_in  = 1'b0;
               ovf_in     = 1'b0;
            end
         end
         ST_FIND_RD: begin
            if (find_done) begin
               if (found_ff) begin
                  placed_in = 1'b1;
                  ux_in     = bx_ff;
                  uy_in     = by_ff;
                  uw_in     = XW'(tw_ff);
                  uh_in     = XW'(th_ff);
                  idx_in    = '0;
                  nb_in     = '0;
                  any_in    = 1'b1;
                  if (new_ex > extx_ff) extx_in = new_ex;
                  if (new_ey > exty_ff) exty_in = new_ey;
               end else if (rot_ff && !rot_try_ff) begin
                  rot_try_in = 1'b1;
                  tw_in      = h_ff;
                  th_in      = w_ff;
                  idx_in     = '0;
               end
            end
         end
         ST_FIND_EV: sc_en = 1'b1;
         ST_FIND_CMP: begin
            if (better) begin
               found_in = 1'b1;
               bp_in    = sc_p;
               bs_in    = sc_s;
               bx_in    = sc_x;
               by_in    = sc_y;
            end
            idx_in = idx_ff + CW'(1);
         end
         ST_PASS1_RD: begin
            if (pass_done) idx_in = '0;
         end
         // keep entries that the placement leaves alone
         ST_PASS1_EV: begin
            if (!a_ovl) begin
               b_we    = 1'b1;
               b_wdata = {1'b0, a_rdata[EW-2:0]};
               nb_in   = nb_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
         end
         ST_PASS2_RD: begin
            if (pass_done) begin
               if (nb_ff == '0) begin
                  idx_in = '0;
                  m_in   = '0;
               end else begin
                  idx_in = nb_ff - CW'(1);
               end
            end
         end
         ST_PASS2_EV: begin
            if (a_ovl) begin
               cur_in = a_rdata;
               k_in   = '0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         // append at most one split fragment per cycle; a fragment with no room sets the overflow flag
         ST_FRAG: begin
            if (frag_en[k_ff]) begin
               if (nb_room) begin
                  b_we    = 1'b1;
                  b_wdata = frag_data[k_ff];
                  nb_in   = nb_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            k_in = k_ff + 2'd1;
            if (k_ff == FRAG_LAST) idx_in = idx_ff + CW'(1);
         end
         ST_PR_I_RD: b_raddr = idx_ff[AW-1:0];
         ST_PR_I_EV: begin
            cur_in = b_rdata;
            jdx_in = idx_ff + CW'(1);
         end
         ST_PR_J_RD: begin
            b_raddr = jdx_ff[AW-1:0];
            if (j_done) begin
               if (idx_zero) begin
                  m_in = '0;
               end else begin
                  idx_in = idx_ff - CW'(1);
               end
            end
         end
         // containment test, deleted entries carry a mark bit
         ST_PR_J_EV: begin
            if (b_del) begin
               jdx_in = jdx_ff + CW'(1);
            end else if (cur_in_b) begin
               b_we    = 1'b1;
               b_waddr = idx_ff[AW-1:0];
               b_wdata = {1'b1, cur_ff[EW-2:0]};
               if (idx_zero) begin
                  m_in = '0;
               end else begin
                  idx_in = idx_ff - CW'(1);
               end
            end else if (b_in_cur) begin
               b_we    = 1'b1;
               b_waddr = jdx_ff[AW-1:0];
               b_wdata = {1'b1, b_rdata[EW-2:0]};
               jdx_in  = jdx_ff + CW'(1);
            end else begin
               jdx_in = jdx_ff + CW'(1);
            end
         end
         ST_CMP_RD: begin
            b_raddr = idx_ff[AW-1:0];
            if (cmp_done) cnt_in = m_ff;
         end
         // copy survivors back into the free list
         ST_CMP_EV: begin
            if (!b_del) begin
               a_we    = 1'b1;
               a_waddr = m_ff[AW-1:0];
               a_wdata = {1'b0, b_rdata[EW-2:0]};
               m_in    = m_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
         end
         ST_POW2: begin
            if (p2x_ff < extx_ff) p2x_in = p2x_ff << 1;
            if (p2y_ff < exty_ff) p2y_in = p2y_ff << 1;
         end
         ST_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_placed_in = placed_ff;
            rsp_x_in      = placed_ff ? 16'(ux_ff) : 16'd0;
            rsp_y_in      = placed_ff ? 16'(uy_ff) : 16'd0;
            rsp_rot_in    = placed_ff & rot_try_ff;
            rsp_ovf_in    = placed_ff & ovf_ff;
            if (!mode_ff[MODE_SMART]) begin
               rsp_uw_in = 17'(bmw_ff);
               rsp_uh_in = 17'(bmh_ff);
            end else if (!any_ff) begin
               rsp_uw_in = '0;
               rsp_uh_in = '0;
            end else begin
               rsp_uw_in = 17'(size_w);
               rsp_uh_in = 17'(size_h);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         bmw_ff        <= BIN_MAX_RESET;
         bmh_ff        <= BIN_MAX_RESET;
         pad_ff        <= '0;
         border_ff     <= '0;
         heur_ff       <= HEUR_SHORT_SIDE;
         rot_ff        <= 1'b0;
         mode_ff       <= '0;
         cnt_ff        <= CW'(1);
         extx_ff       <= '0;
         exty_ff       <= '0;
         p2x_ff        <= XW'(1);
         p2y_ff        <= XW'(1);
         any_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bmw_ff        <= bmw_in;
         bmh_ff        <= bmh_in;
         pad_ff        <= pad_in;
         border_ff     <= border_in;
         heur_ff       <= heur_in;
         rot_ff        <= rot_in;
         mode_ff       <= mode_in;
         cnt_ff        <= cnt_in;
         extx_ff       <= extx_in;
         exty_ff       <= exty_in;
         p2x_ff        <= p2x_in;
         p2y_ff        <= p2y_in;
         any_ff        <= any_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      h_ff          <= h_in;
      tw_ff         <= tw_in;
      th_ff         <= th_in;
      rot_try_ff    <= rot_try_in;
      idx_ff        <= idx_in;
      jdx_ff        <= jdx_in;
      nb_ff         <= nb_in;
      m_ff          <= m_in;
      found_ff      <= found_in;
      bp_ff         <= bp_in;
      bs_ff         <= bs_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      ux_ff         <= ux_in;
      uy_ff         <= uy_in;
      uw_ff         <= uw_in;
      uh_ff         <= uh_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      placed_ff     <= placed_in;
      ovf_ff        <= ovf_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_rot_ff    <= rsp_rot_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_uw_ff     <= rsp_uw_in;
      rsp_uh_ff     <= rsp_uh_in;
   end

   // ports
   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_placed        = rsp_placed_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_rotated       = rsp_rot_ff;
   assign rsp_used_width    = rsp_uw_ff;
   assign rsp_used_height   = rsp_uh_ff;
   assign rsp_list_overflow = rsp_ovf_ff;

endmodule
